### rtl/uvs_pkg.sv
// Shared types, constants and helper functions of the UV sphere vertex generator.
package uvs_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DIV_W = 33;
  localparam int ANG_W = 24;
  localparam int TEX_W = 16;
  localparam int CS_W = 33;
  localparam int Z_W = 27;
  localparam int TRIG_W = 32;
  localparam int POST_LAT = 4;

  localparam logic [8:0] MIN_STACKS = 9'd2;
  localparam logic [8:0] MAX_STACKS = 9'd256;
  localparam logic [8:0] MIN_SLICES = 9'd3;
  localparam logic [8:0] MAX_SLICES = 9'd256;

  localparam logic [15:0] RADIUS_RST = 16'd256;
  localparam logic [8:0] STACKS_RST = 9'd20;
  localparam logic [8:0] SLICES_RST = 9'd20;

  localparam logic [29:0] CORDIC_X0 = 30'd652032874;
  localparam logic [26:0] RAD_SCALE = 27'd105414357;

  localparam logic signed [15:0] NORM_ONE = 16'sd16384;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_STACKS = 2'd1,
    REG_SLICES = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PT_INTERIOR = 2'd0,
    PT_NORTH    = 2'd1,
    PT_SOUTH    = 2'd2,
    PT_ERROR    = 2'd3
  } point_class_e;

  typedef struct packed {
    point_class_e cls;
    logic [16:0]  vidx;
  } vtx_meta_t;

  typedef struct packed {
    vtx_meta_t   meta;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
  } vtx_side_t;

  function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      5'd0:    r = 27'sd13176795;
      5'd1:    r = 27'sd7778716;
      5'd2:    r = 27'sd4110060;
      5'd3:    r = 27'sd2086331;
      5'd4:    r = 27'sd1047214;
      5'd5:    r = 27'sd524117;
      5'd6:    r = 27'sd262123;
      5'd7:    r = 27'sd131069;
      5'd8:    r = 27'sd65536;
      5'd9:    r = 27'sd32768;
      5'd10:   r = 27'sd16384;
      5'd11:   r = 27'sd8192;
      5'd12:   r = 27'sd4096;
      5'd13:   r = 27'sd2048;
      5'd14:   r = 27'sd1024;
      5'd15:   r = 27'sd512;
      5'd16:   r = 27'sd256;
      5'd17:   r = 27'sd128;
      5'd18:   r = 27'sd64;
      5'd19:   r = 27'sd32;
      5'd20:   r = 27'sd16;
      5'd21:   r = 27'sd8;
      5'd22:   r = 27'sd4;
      5'd23:   r = 27'sd2;
      default: r = 27'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [16:0] sat_pos(input logic signed [63:0] v);
    logic signed [16:0] r;
    if (v < -64'sd65536) begin
      r = -17'sd65536;
    end else if (v > 64'sd65535) begin
      r = 17'sd65535;
    end else begin
      r = 17'(v);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_norm(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v < -64'sd16384) begin
      r = -16'sd16384;
    end else if (v > 64'sd16384) begin
      r = 16'sd16384;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

endpackage

### rtl/uvs_div_pipe.sv
// Pipelined restoring divider by a 9-bit divisor, one quotient bit per stage.
module uvs_div_pipe #(
  parameter int DW = uvs_pkg::DIV_W,
  parameter int QW = uvs_pkg::ANG_W
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [8:0]    divisor_i,
  output logic [QW-1:0] quot_o
);

  logic [8:0]    rem_q [DW];
  logic [DW-1:0] num_q [DW];
  logic [QW-1:0] quo_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [8:0]    rem_p;
    logic [DW-1:0] num_p;
    logic [QW-1:0] quo_p;
    logic [9:0]    trial;
    logic          ge;
    logic [8:0]    rem_d;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign num_p = dividend_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign num_p = num_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign trial = {rem_p, num_p[DW-1]};
    assign ge    = trial >= {1'b0, divisor_i};
    assign rem_d = ge ? 9'(trial - {1'b0, divisor_i}) : trial[8:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        num_q[k] <= num_p << 1;
        quo_q[k] <= {quo_p[QW-2:0], ge};
      end
    end
  end

  assign quot_o = quo_q[DW-1];

endmodule

### rtl/uvs_cordic.sv
// Pipelined rotation-mode CORDIC that turns a 24-bit turn angle into cosine and sine.
module uvs_cordic #(
  parameter int STEPS = uvs_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [uvs_pkg::ANG_W-1:0]          turn_i,
  output logic signed [uvs_pkg::TRIG_W-1:0]  cos_o,
  output logic signed [uvs_pkg::TRIG_W-1:0]  sin_o
);

  localparam int XW = uvs_pkg::CS_W;
  localparam int ZW = uvs_pkg::Z_W;
  localparam int TRIG_W = uvs_pkg::TRIG_W;

  logic [48:0]          zprod;
  logic signed [ZW-1:0] za_q;
  logic [1:0]           qa_q;

  logic signed [XW-1:0] x_q [STEPS];
  logic signed [XW-1:0] y_q [STEPS];
  logic signed [ZW-1:0] z_q [STEPS];
  logic [1:0]           q_q [STEPS];

  assign zprod = 49'(turn_i[21:0]) * 49'(uvs_pkg::RAD_SCALE);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      za_q <= $signed({2'b00, zprod[48:24]});
      qa_q <= turn_i[23:22];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [XW-1:0] xp;
    logic signed [XW-1:0] yp;
    logic signed [ZW-1:0] zp;
    logic [1:0]           qp;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] at;

    if (i == 0) begin : g_first
      assign xp = $signed({3'b000, uvs_pkg::CORDIC_X0});
      assign yp = '0;
      assign zp = za_q;
      assign qp = qa_q;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
      assign qp = q_q[i-1];
    end

    assign xs = xp >>> i;
    assign ys = yp >>> i;
    assign at = uvs_pkg::atan_q24(5'(i));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zp[ZW-1]) begin
          x_q[i] <= xp - ys;
          y_q[i] <= yp + xs;
          z_q[i] <= zp - at;
        end else begin
          x_q[i] <= xp + ys;
          y_q[i] <= yp - xs;
          z_q[i] <= zp + at;
        end
        q_q[i] <= qp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (q_q[STEPS-1])
        2'd0: begin
          cos_o <= TRIG_W'(x_q[STEPS-1]);
          sin_o <= TRIG_W'(y_q[STEPS-1]);
        end
        2'd1: begin
          cos_o <= TRIG_W'(-y_q[STEPS-1]);
          sin_o <= TRIG_W'(x_q[STEPS-1]);
        end
        2'd2: begin
          cos_o <= TRIG_W'(-x_q[STEPS-1]);
          sin_o <= TRIG_W'(-y_q[STEPS-1]);
        end
        default: begin
          cos_o <= TRIG_W'(y_q[STEPS-1]);
          sin_o <= TRIG_W'(-x_q[STEPS-1]);
        end
      endcase
    end
  end

endmodule

### rtl/uvs_post.sv
// Multiply, round and saturate stages that build position and normal from sine and cosine.
module uvs_post (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [15:0]                       radius_i,
  input  logic signed [uvs_pkg::TRIG_W-1:0] cos_phi_i,
  input  logic signed [uvs_pkg::TRIG_W-1:0] sin_phi_i,
  input  logic signed [uvs_pkg::TRIG_W-1:0] cos_theta_i,
  input  logic signed [uvs_pkg::TRIG_W-1:0] sin_theta_i,
  output logic signed [16:0]                pos_x_o,
  output logic signed [16:0]                pos_y_o,
  output logic signed [16:0]                pos_z_o,
  output logic signed [15:0]                norm_x_o,
  output logic signed [15:0]                norm_y_o,
  output logic signed [15:0]                norm_z_o
);

  logic signed [16:0] rs;
  logic signed [63:0] pst_q;
  logic signed [63:0] pct_q;
  logic signed [48:0] rcp_q;
  logic signed [uvs_pkg::TRIG_W-1:0] cp_q;

  logic signed [63:0] px_r;
  logic signed [63:0] pz_r;
  logic signed [63:0] nx_r;
  logic signed [63:0] nz_r;
  logic signed [63:0] ny_r;
  logic signed [63:0] py_r;
  logic signed [32:0] px_q;
  logic signed [32:0] pz_q;
  logic signed [15:0] nx2_q, ny2_q, nz2_q;
  logic signed [16:0] py2_q;

  logic signed [49:0] rpx_q;
  logic signed [49:0] rpz_q;
  logic signed [15:0] nx3_q, ny3_q, nz3_q;
  logic signed [16:0] py3_q;

  logic signed [63:0] fx_r;
  logic signed [63:0] fz_r;

  assign rs = $signed({1'b0, radius_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pst_q <= sin_phi_i * sin_theta_i;
      pct_q <= sin_phi_i * cos_theta_i;
      rcp_q <= rs * cos_phi_i;
      cp_q  <= cos_phi_i;
    end
  end

  assign px_r = (pst_q + 64'sd536870912) >>> 30;
  assign pz_r = (pct_q + 64'sd536870912) >>> 30;
  assign nx_r = (pst_q + 64'sd35184372088832) >>> 46;
  assign nz_r = (pct_q + 64'sd35184372088832) >>> 46;
  assign ny_r = (64'(cp_q) + 64'sd32768) >>> 16;
  assign py_r = (64'(rcp_q) + 64'sd536870912) >>> 30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= 33'(px_r);
      pz_q  <= 33'(pz_r);
      nx2_q <= uvs_pkg::sat_norm(nx_r);
      nz2_q <= uvs_pkg::sat_norm(nz_r);
      ny2_q <= uvs_pkg::sat_norm(ny_r);
      py2_q <= uvs_pkg::sat_pos(py_r);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rpx_q <= rs * px_q;
      rpz_q <= rs * pz_q;
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
      nz3_q <= nz2_q;
      py3_q <= py2_q;
    end
  end

  assign fx_r = (64'(rpx_q) + 64'sd536870912) >>> 30;
  assign fz_r = (64'(rpz_q) + 64'sd536870912) >>> 30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_x_o  <= uvs_pkg::sat_pos(fx_r);
      pos_z_o  <= uvs_pkg::sat_pos(fz_r);
      pos_y_o  <= py3_q;
      norm_x_o <= nx3_q;
      norm_y_o <= ny3_q;
      norm_z_o <= nz3_q;
    end
  end

endmodule

### rtl/uv_sphere_vertex_generator.sv
// Top level of the UV sphere vertex generator: config registers, pipeline control, output stage.
// Throughput is one transaction per cycle while the output is not stalled; the 33-stage
// dividers and the CORDIC pipeline set it.
// A stall at the output freezes the whole pipeline until the result is taken.
// Reset clears all valid bits and loads radius 256 and 20 stacks and slices.
module uv_sphere_vertex_generator #(
  parameter int CORDIC_STEPS = uvs_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [8:0]         ring_number_i,
  input  logic [8:0]         slice_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [15:0]        tex_u_o,
  output logic [15:0]        tex_v_o,
  output logic [16:0]        vertex_index_o,
  output logic               range_error_o
);

  localparam int DW = uvs_pkg::DIV_W;
  localparam int CL = CORDIC_STEPS + 2;
  localparam int SL = CL + uvs_pkg::POST_LAT;
  localparam int NPIPE = DW + SL;

  logic [15:0] radius_q;
  logic [8:0]  stack_q;
  logic [8:0]  slice_q;
  logic [8:0]  stacks;
  logic [8:0]  slices;
  logic        en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= uvs_pkg::RADIUS_RST;
      stack_q  <= uvs_pkg::STACKS_RST;
      slice_q  <= uvs_pkg::SLICES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uvs_pkg::REG_RADIUS: radius_q <= cfg_data_i;
        uvs_pkg::REG_STACKS: stack_q  <= cfg_data_i[8:0];
        uvs_pkg::REG_SLICES: slice_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  assign stacks = (stack_q < uvs_pkg::MIN_STACKS) ? uvs_pkg::MIN_STACKS :
                  (stack_q > uvs_pkg::MAX_STACKS) ? uvs_pkg::MAX_STACKS : stack_q;
  assign slices = (slice_q < uvs_pkg::MIN_SLICES) ? uvs_pkg::MIN_SLICES :
                  (slice_q > uvs_pkg::MAX_SLICES) ? uvs_pkg::MAX_SLICES : slice_q;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  uvs_pkg::point_class_e cls_d;
  logic [18:0]           vprod;
  logic [16:0]           vidx_d;

  always_comb begin
    if (ring_number_i > stacks) begin
      cls_d = uvs_pkg::PT_ERROR;
    end else if (ring_number_i == 9'd0) begin
      cls_d = uvs_pkg::PT_NORTH;
    end else if (ring_number_i == stacks) begin
      cls_d = uvs_pkg::PT_SOUTH;
    end else if (slice_number_i > slices) begin
      cls_d = uvs_pkg::PT_ERROR;
    end else begin
      cls_d = uvs_pkg::PT_INTERIOR;
    end
  end

  assign vprod  = 19'(9'(ring_number_i - 9'd1)) * 19'(10'(slices) + 10'd1);
  assign vidx_d = 17'(19'd1 + vprod +
                  ((cls_d == uvs_pkg::PT_INTERIOR) ? 19'(slice_number_i) : 19'd0));

  logic                s0_vld_q;
  uvs_pkg::vtx_meta_t  s0_meta_q;
  logic [DW-1:0]       phi_num_q, theta_num_q, texu_num_q, texv_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_meta_q.cls  <= cls_d;
      s0_meta_q.vidx <= vidx_d;
      phi_num_q      <= (DW'(ring_number_i) << 23) + DW'(stacks[8:1]);
      theta_num_q    <= (DW'(slice_number_i) << 24) + DW'(slices[8:1]);
      texu_num_q     <= (DW'(slice_number_i) << 15) + DW'(slices[8:1]);
      texv_num_q     <= (DW'(ring_number_i) << 15) + DW'(stacks[8:1]);
    end
  end

  logic [uvs_pkg::ANG_W-1:0] phi_turn, theta_turn;
  logic [uvs_pkg::TEX_W-1:0] texu, texv;

  uvs_div_pipe #(.DW(DW), .QW(uvs_pkg::ANG_W)) u_div_phi (
    .clk_i, .en_i(en), .dividend_i(phi_num_q), .divisor_i(stacks), .quot_o(phi_turn)
  );
  uvs_div_pipe #(.DW(DW), .QW(uvs_pkg::ANG_W)) u_div_theta (
    .clk_i, .en_i(en), .dividend_i(theta_num_q), .divisor_i(slices), .quot_o(theta_turn)
  );
  uvs_div_pipe #(.DW(DW), .QW(uvs_pkg::TEX_W)) u_div_texu (
    .clk_i, .en_i(en), .dividend_i(texu_num_q), .divisor_i(slices), .quot_o(texu)
  );
  uvs_div_pipe #(.DW(DW), .QW(uvs_pkg::TEX_W)) u_div_texv (
    .clk_i, .en_i(en), .dividend_i(texv_num_q), .divisor_i(stacks), .quot_o(texv)
  );

  uvs_pkg::vtx_meta_t meta_q [DW];
  uvs_pkg::vtx_side_t side_q [SL];
  uvs_pkg::vtx_side_t side_in;

  assign side_in.meta  = meta_q[DW-1];
  assign side_in.tex_u = texu;
  assign side_in.tex_v = texv;

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= s0_meta_q;
      for (int k = 1; k < DW; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
      side_q[0] <= side_in;
      for (int k = 1; k < SL; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  logic signed [uvs_pkg::TRIG_W-1:0] cos_phi, sin_phi, cos_theta, sin_theta;

  uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_phi (
    .clk_i, .en_i(en), .turn_i(phi_turn), .cos_o(cos_phi), .sin_o(sin_phi)
  );
  uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_theta (
    .clk_i, .en_i(en), .turn_i(theta_turn), .cos_o(cos_theta), .sin_o(sin_theta)
  );

  logic signed [16:0] p_x, p_y, p_z;
  logic signed [15:0] n_x, n_y, n_z;

  uvs_post u_post (
    .clk_i,
    .en_i        (en),
    .radius_i    (radius_q),
    .cos_phi_i   (cos_phi),
    .sin_phi_i   (sin_phi),
    .cos_theta_i (cos_theta),
    .sin_theta_i (sin_theta),
    .pos_x_o     (p_x),
    .pos_y_o     (p_y),
    .pos_z_o     (p_z),
    .norm_x_o    (n_x),
    .norm_y_o    (n_y),
    .norm_z_o    (n_z)
  );

  logic [NPIPE-1:0] vld_q;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NPIPE-2:0], s0_vld_q};
      out_valid_q <= vld_q[NPIPE-1];
    end
  end

  assign out_valid_o = out_valid_q;

  uvs_pkg::vtx_side_t fin;
  logic signed [16:0] radius_s;

  assign fin      = side_q[SL-1];
  assign radius_s = $signed({1'b0, radius_q});

  logic signed [16:0] pos_x_d, pos_y_d, pos_z_d;
  logic signed [15:0] norm_x_d, norm_y_d, norm_z_d;
  logic [15:0]        tex_u_d, tex_v_d;
  logic [16:0]        vertex_index_d;
  logic               range_error_d;

  always_comb begin
    pos_x_d        = '0;
    pos_y_d        = '0;
    pos_z_d        = '0;
    norm_x_d       = '0;
    norm_y_d       = '0;
    norm_z_d       = '0;
    tex_u_d        = '0;
    tex_v_d        = '0;
    vertex_index_d = '0;
    range_error_d  = 1'b0;
    case (fin.meta.cls)
      uvs_pkg::PT_NORTH: begin
        pos_y_d  = radius_s;
        norm_y_d = uvs_pkg::NORM_ONE;
      end
      uvs_pkg::PT_SOUTH: begin
        pos_y_d        = -radius_s;
        norm_y_d       = -uvs_pkg::NORM_ONE;
        vertex_index_d = fin.meta.vidx;
      end
      uvs_pkg::PT_ERROR: begin
        range_error_d = 1'b1;
      end
      default: begin
        pos_x_d        = p_x;
        pos_y_d        = p_y;
        pos_z_d        = p_z;
        norm_x_d       = n_x;
        norm_y_d       = n_y;
        norm_z_d       = n_z;
        tex_u_d        = fin.tex_u;
        tex_v_d        = fin.tex_v;
        vertex_index_d = fin.meta.vidx;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_o        <= pos_x_d;
      pos_y_o        <= pos_y_d;
      pos_z_o        <= pos_z_d;
      norm_x_o       <= norm_x_d;
      norm_y_o       <= norm_y_d;
      norm_z_o       <= norm_z_d;
      tex_u_o        <= tex_u_d;
      tex_v_o        <= tex_v_d;
      vertex_index_o <= vertex_index_d;
      range_error_o  <= range_error_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |->
      (pos_x_o == 17'sd0 && pos_y_o == 17'sd0 && pos_z_o == 17'sd0 &&
       norm_x_o == 16'sd0 && norm_y_o == 16'sd0 && norm_z_o == 16'sd0))
    else $error("error result carries nonzero geometry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |->
      (tex_u_o == 16'd0 && tex_v_o == 16'd0 && vertex_index_o == 17'd0))
    else $error("error result carries nonzero texture or index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(vld_q) && $stable(s0_vld_q)))
    else $error("pipeline moved while the output was stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !range_error_o) |-> (tex_u_o <= 16'd32768 && tex_v_o <= 16'd32768))
    else $error("texture coordinate above one");

endmodule
